// ----- hdl/uvs_pkg.sv -----
// Shared types and constants of the UV sphere vertex generator.
package uvs_pkg;

  localparam int IDX_W = 10;
  localparam int RAD_W = 16;
  localparam int POS_W = 17;
  localparam int NORM_W = 16;
  localparam int TEX_W = 17;
  localparam int ANG_W = 32;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [IDX_W-1:0] MAX_SEGMENTS = IDX_W'(1023);
  localparam logic [IDX_W-1:0] MIN_SLICES = IDX_W'(3);
  localparam logic [IDX_W-1:0] MIN_STACKS = IDX_W'(2);

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(256);
  localparam logic [IDX_W-1:0] SLICES_RESET = IDX_W'(16);
  localparam logic [IDX_W-1:0] STACKS_RESET = IDX_W'(16);

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_STACKS = 2'd2;

  // Long division of index by count: one integer bit and DIV_FRAC_BITS fraction bits.
  localparam int DIV_FRAC_BITS = 33;
  localparam int DIV_BITS = 3;
  localparam int DIV_STAGES = DIV_FRAC_BITS / DIV_BITS;
  localparam int QUO_W = DIV_FRAC_BITS + 1;

  // Sine and cosine in Q2.30.
  localparam int FRAC_W = 30;
  localparam int HORNER_STEPS = 4;
  localparam int SC_STAGES = 3 + 2 * HORNER_STEPS;
  localparam logic [FRAC_W:0] Q30_ONE = 31'h4000_0000;
  localparam logic [FRAC_W:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int unsigned SIN_DIV [HORNER_STEPS] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [HORNER_STEPS] = '{90, 56, 30, 12};

  typedef struct packed {
    logic             err;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_t;

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ----- hdl/uvs_div.sv -----
// Pipelined restoring divider giving index/count as a fixed-point fraction.
module uvs_div (
  input  logic                            clk,
  input  logic [uvs_pkg::DIV_STAGES-1:0]  en,
  input  logic [uvs_pkg::IDX_W-1:0]       num,
  input  logic [uvs_pkg::IDX_W-1:0]       den,
  output logic [uvs_pkg::QUO_W-1:0]       quo
);

  logic [uvs_pkg::IDX_W-1:0] rem_r [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::QUO_W-1:0] quo_r [uvs_pkg::DIV_STAGES];

  for (genvar k = 0; k < uvs_pkg::DIV_STAGES; k++) begin : g_stage
    logic [uvs_pkg::IDX_W-1:0] rem_in;
    logic [uvs_pkg::IDX_W-1:0] rem_w;
    logic [uvs_pkg::QUO_W-1:0] quo_in;
    logic [uvs_pkg::QUO_W-1:0] quo_w;

    if (k == 0) begin : g_first
      // The index never exceeds the count, so the integer part is one bit.
      always_comb begin
        if (num >= den) begin
          rem_in = num - den;
          quo_in = uvs_pkg::QUO_W'(1);
        end else begin
          rem_in = num;
          quo_in = '0;
        end
      end
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      logic [uvs_pkg::IDX_W:0] dbl;
      rem_w = rem_in;
      quo_w = quo_in;
      for (int b = 0; b < uvs_pkg::DIV_BITS; b++) begin
        dbl = {rem_w, 1'b0};
        if (dbl >= {1'b0, den}) begin
          rem_w = uvs_pkg::IDX_W'(dbl - {1'b0, den});
          quo_w = {quo_w[uvs_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_w = dbl[uvs_pkg::IDX_W-1:0];
          quo_w = {quo_w[uvs_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_w;
        quo_r[k] <= quo_w;
      end
    end
  end

  assign quo = quo_r[uvs_pkg::DIV_STAGES-1];

endmodule

// ----- hdl/uvs_sincos.sv -----
// Pipelined sine and cosine of an angle in turns, by octant folding and Horner series.
module uvs_sincos (
  input  logic                           clk,
  input  logic [uvs_pkg::SC_STAGES-1:0]  en,
  input  logic [uvs_pkg::ANG_W-1:0]      ang,
  output logic signed [31:0]             sn,
  output logic signed [31:0]             cs
);

  localparam int FW = uvs_pkg::FRAC_W;
  localparam int NH = uvs_pkg::HORNER_STEPS;
  localparam int ANG_W_TOP = uvs_pkg::ANG_W - 1;

  logic [FW-1:0] x0;
  logic [2:0]    oct0;
  logic [FW-1:0] x1;
  logic [FW-1:0] xx1;
  logic [2:0]    oct1;

  logic [FW-1:0] qs_r  [NH];
  logic [FW-1:0] qc_r  [NH];
  logic [FW-1:0] xd_r  [NH];
  logic [FW-1:0] xxd_r [NH];
  logic [2:0]    octd_r[NH];
  logic [FW:0]   ps_r  [NH];
  logic [FW:0]   pc_r  [NH];
  logic [FW-1:0] xm_r  [NH];
  logic [FW-1:0] xxm_r [NH];
  logic [2:0]    octm_r[NH];

  logic [FW-1:0]     fold;
  logic [2*FW:0]     x_prod;
  logic [2*FW-1:0]   xx_prod;

  // Fold into the first octant and scale turns to radians.
  always_comb begin
    if (ang[29]) begin
      fold = FW'(31'h2000_0000 - {2'b00, ang[28:0]});
    end else begin
      fold = {1'b0, ang[28:0]};
    end
    x_prod = (2*FW+1)'(fold) * (2*FW+1)'(uvs_pkg::HALF_PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0   <= x_prod[2*FW-1:FW];
      oct0 <= ang[ANG_W_TOP:29];
    end
  end

  assign xx_prod = (2*FW)'(x0) * (2*FW)'(x0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1   <= x0;
      xx1  <= xx_prod[2*FW-1:FW];
      oct1 <= oct0;
    end
  end

  for (genvar k = 0; k < NH; k++) begin : g_horner
    localparam int unsigned DS = uvs_pkg::SIN_DIV[k];
    localparam int unsigned DC = uvs_pkg::COS_DIV[k];
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    localparam logic [31:0] MS = 32'(((64'd1 << (FW + LS)) + DS - 1) / DS);
    localparam logic [31:0] MC = 32'(((64'd1 << (FW + LC)) + DC - 1) / DC);

    logic [FW:0]   ps_in;
    logic [FW:0]   pc_in;
    logic [FW-1:0] x_in;
    logic [FW-1:0] xx_in;
    logic [2:0]    oct_in;
    logic [62:0]   qs_prod;
    logic [62:0]   qc_prod;
    logic [FW:0]   ts;
    logic [FW:0]   tc;
    logic [FW-1:0] s_mul;
    logic [2*FW:0] ps_prod;
    logic [2*FW:0] pc_prod;

    if (k == 0) begin : g_first
      assign ps_in  = {1'b0, xx1};
      assign pc_in  = {1'b0, xx1};
      assign x_in   = x1;
      assign xx_in  = xx1;
      assign oct_in = oct1;
    end else begin : g_next
      assign ps_in  = ps_r[k-1];
      assign pc_in  = pc_r[k-1];
      assign x_in   = xm_r[k-1];
      assign xx_in  = xxm_r[k-1];
      assign oct_in = octm_r[k-1];
    end

    // Division by a small constant through an exact reciprocal.
    assign qs_prod = 63'(ps_in) * 63'(MS);
    assign qc_prod = 63'(pc_in) * 63'(MC);

    always_ff @(posedge clk) begin
      if (en[2 + 2*k]) begin
        qs_r[k]   <= FW'(qs_prod >> (FW + LS));
        qc_r[k]   <= FW'(qc_prod >> (FW + LC));
        xd_r[k]   <= x_in;
        xxd_r[k]  <= xx_in;
        octd_r[k] <= oct_in;
      end
    end

    // The last sine step multiplies by x instead of x squared.
    if (k == NH - 1) begin : g_last
      assign s_mul = xd_r[k];
    end else begin : g_mid
      assign s_mul = xxd_r[k];
    end

    assign ts = uvs_pkg::Q30_ONE - {1'b0, qs_r[k]};
    assign tc = uvs_pkg::Q30_ONE - {1'b0, qc_r[k]};
    assign ps_prod = (2*FW+1)'(s_mul) * (2*FW+1)'(ts);
    assign pc_prod = (2*FW+1)'(xxd_r[k]) * (2*FW+1)'(tc);

    always_ff @(posedge clk) begin
      if (en[3 + 2*k]) begin
        ps_r[k]   <= ps_prod[2*FW:FW];
        pc_r[k]   <= pc_prod[2*FW:FW];
        xm_r[k]   <= xd_r[k];
        xxm_r[k]  <= xxd_r[k];
        octm_r[k] <= octd_r[k];
      end
    end
  end

  logic signed [31:0] s_fin;
  logic signed [31:0] c_fin;
  logic signed [31:0] sn_w;
  logic signed [31:0] cs_w;

  assign s_fin = $signed({1'b0, ps_r[NH-1]});
  assign c_fin = $signed({1'b0, uvs_pkg::Q30_ONE - (pc_r[NH-1] >> 1)});

  // Map back to the full circle by octant symmetry.
  always_comb begin
    case (octm_r[NH-1])
      3'd0: begin sn_w = s_fin;  cs_w = c_fin;  end
      3'd1: begin sn_w = c_fin;  cs_w = s_fin;  end
      3'd2: begin sn_w = c_fin;  cs_w = -s_fin; end
      3'd3: begin sn_w = s_fin;  cs_w = -c_fin; end
      3'd4: begin sn_w = -s_fin; cs_w = -c_fin; end
      3'd5: begin sn_w = -c_fin; cs_w = -s_fin; end
      3'd6: begin sn_w = -c_fin; cs_w = s_fin;  end
      default: begin sn_w = -s_fin; cs_w = c_fin; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[uvs_pkg::SC_STAGES-1]) begin
      sn <= sn_w;
      cs <= cs_w;
    end
  end

endmodule

// ----- hdl/uv_sphere_vertex_generator_top.sv -----
// Top level of the UV sphere vertex generator: config registers and the vertex pipeline.
//
// Each input beat carries one grid point (slice_index, stack_index) and yields one output
// beat with the vertex position (Q8.8), unit normal (Q1.14), texture coordinates (Q1.16)
// and an index_error flag that is set when an index above its count was saturated.
// The pipeline takes one beat per cycle while in_stall is low and has one input stage,
// eleven stages of the two parallel long dividers that turn each index into a fraction of
// its count (three quotient bits per stage), one stage that forms the angles and texture
// coordinates, eleven stages of the two sine/cosine units, and four stages that combine
// the angles, scale by the radius and round. Every stage holds its own valid bit and moves
// forward whenever the stage after it is empty or moving, so bubbles close up and new beats
// keep entering while a finished vertex waits on a stalled output. sphere_radius, slice_count
// and stack_count are written through the APB port and must only be changed while no beat
// is in flight; counts below their minimum (three slices, two stacks) are used as the minimum.
module uv_sphere_vertex_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [uvs_pkg::APB_AW-1:0]         paddr,
  input  logic [uvs_pkg::APB_DW-1:0]         pwdata,
  output logic [uvs_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [uvs_pkg::IDX_W-1:0]          slice_index,
  input  logic [uvs_pkg::IDX_W-1:0]          stack_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]   pos_z,
  output logic signed [uvs_pkg::NORM_W-1:0]  norm_x,
  output logic signed [uvs_pkg::NORM_W-1:0]  norm_y,
  output logic signed [uvs_pkg::NORM_W-1:0]  norm_z,
  output logic [uvs_pkg::TEX_W-1:0]          tex_u,
  output logic [uvs_pkg::TEX_W-1:0]          tex_v,
  output logic                               index_error
);

  localparam int IW = uvs_pkg::IDX_W;
  localparam int QW = uvs_pkg::QUO_W;

  // Stage numbering along the pipeline.
  localparam int ST_DIV   = 1;
  localparam int ST_ANG   = ST_DIV + uvs_pkg::DIV_STAGES;
  localparam int ST_SC    = ST_ANG + 1;
  localparam int ST_MUL   = ST_SC + uvs_pkg::SC_STAGES;
  localparam int ST_RND   = ST_MUL + 1;
  localparam int ST_SCALE = ST_RND + 1;
  localparam int ST_OUT   = ST_SCALE + 1;
  localparam int NST      = ST_OUT + 1;

  // Configuration registers.
  logic [uvs_pkg::RAD_W-1:0] sphere_radius;
  logic [IW-1:0]             slice_count;
  logic [IW-1:0]             stack_count;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= uvs_pkg::RADIUS_RESET;
      slice_count   <= uvs_pkg::SLICES_RESET;
      stack_count   <= uvs_pkg::STACKS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        uvs_pkg::REG_RADIUS: sphere_radius <= pwdata[uvs_pkg::RAD_W-1:0];
        uvs_pkg::REG_SLICES: slice_count   <= pwdata[IW-1:0];
        uvs_pkg::REG_STACKS: stack_count   <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uvs_pkg::REG_RADIUS: prdata = uvs_pkg::APB_DW'(sphere_radius);
      uvs_pkg::REG_SLICES: prdata = uvs_pkg::APB_DW'(slice_count);
      uvs_pkg::REG_STACKS: prdata = uvs_pkg::APB_DW'(stack_count);
      default:             prdata = '0;
    endcase
  end

  // Effective counts, clamped to the supported range.
  logic [IW-1:0] slices;
  logic [IW-1:0] stacks;

  always_comb begin
    slices = (slice_count < uvs_pkg::MIN_SLICES) ? uvs_pkg::MIN_SLICES : slice_count;
    stacks = (stack_count < uvs_pkg::MIN_STACKS) ? uvs_pkg::MIN_STACKS : stack_count;
    if (slices > uvs_pkg::MAX_SEGMENTS) begin
      slices = uvs_pkg::MAX_SEGMENTS;
    end
    if (stacks > uvs_pkg::MAX_SEGMENTS) begin
      stacks = uvs_pkg::MAX_SEGMENTS;
    end
  end

  // Stage valid bits and the advance chain: a stage loads when it is empty or
  // when the stage after it loads as well.
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1 < 0 ? 0 : k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[ST_OUT];

  // Input stage: saturate the indices.
  logic [IW-1:0] i_sat;
  logic [IW-1:0] j_sat;
  logic          err_in;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      i_sat <= (slice_index > slices) ? slices : slice_index;
      j_sat <= (stack_index > stacks) ? stacks : stack_index;
    end
  end

  assign err_in = (slice_index > slices) || (stack_index > stacks);

  // Fractions i/slices and j/stacks with 33 fraction bits.
  logic [QW-1:0] qi;
  logic [QW-1:0] qj;

  uvs_div u_div_i (
    .clk (clk),
    .en  (en[ST_DIV +: uvs_pkg::DIV_STAGES]),
    .num (i_sat),
    .den (slices),
    .quo (qi)
  );

  uvs_div u_div_j (
    .clk (clk),
    .en  (en[ST_DIV +: uvs_pkg::DIV_STAGES]),
    .num (j_sat),
    .den (stacks),
    .quo (qj)
  );

  // Angle stage: theta = i/slices turns and phi = j/(2*stacks) turns, both rounded half up
  // from the truncated quotient. The texture coordinates come from the same quotients.
  logic [uvs_pkg::ANG_W-1:0] theta;
  logic [uvs_pkg::ANG_W-1:0] phi;
  logic [uvs_pkg::TEX_W-1:0] u_w;
  logic [uvs_pkg::TEX_W-1:0] vfrac_w;

  always_ff @(posedge clk) begin
    if (en[ST_ANG]) begin
      theta <= uvs_pkg::ANG_W'(((QW+1)'(qi) + (QW+1)'(1)) >> 1);
      phi   <= uvs_pkg::ANG_W'(((QW+1)'(qj[QW-1:1]) + (QW+1)'(1)) >> 1);
    end
  end

  assign u_w     = uvs_pkg::TEX_W'((19'(qi[QW-1:16]) + 19'd1) >> 1);
  assign vfrac_w = uvs_pkg::TEX_W'((19'(qj[QW-1:16]) + 19'd1) >> 1);

  // Sideband fields that travel alongside the arithmetic.
  uvs_pkg::side_t side [NST];

  for (genvar k = 0; k < NST; k++) begin : g_side
    if (k == 0) begin : g_in
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side[k].err   <= err_in;
          side[k].tex_u <= '0;
          side[k].tex_v <= '0;
        end
      end
    end else if (k == ST_ANG) begin : g_tex
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side[k].err   <= side[k-1].err;
          side[k].tex_u <= u_w;
          side[k].tex_v <= uvs_pkg::TEX_W'(17'd65536 - vfrac_w);
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[k]) begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // Sine and cosine of both angles.
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [31:0] st;
  logic signed [31:0] ct;

  uvs_sincos u_sc_phi (
    .clk (clk),
    .en  (en[ST_SC +: uvs_pkg::SC_STAGES]),
    .ang (phi),
    .sn  (sp),
    .cs  (cp)
  );

  uvs_sincos u_sc_theta (
    .clk (clk),
    .en  (en[ST_SC +: uvs_pkg::SC_STAGES]),
    .ang (theta),
    .sn  (st),
    .cs  (ct)
  );

  // Direction products sin(phi)*cos(theta) and sin(phi)*sin(theta).
  logic signed [63:0] dxp;
  logic signed [63:0] dzp;
  logic signed [31:0] cp_m;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      dxp  <= 64'(sp) * 64'(ct);
      dzp  <= 64'(sp) * 64'(st);
      cp_m <= cp;
    end
  end

  // Round the products back to Q2.30.
  logic signed [31:0] dx;
  logic signed [31:0] dz;
  logic signed [31:0] cp_r;

  always_ff @(posedge clk) begin
    if (en[ST_RND]) begin
      dx   <= 32'(uvs_pkg::round_away(dxp, 30));
      dz   <= 32'(uvs_pkg::round_away(dzp, 30));
      cp_r <= cp_m;
    end
  end

  // Scale by the radius; the normals are the negated direction rounded to Q1.14.
  logic signed [47:0] prx;
  logic signed [47:0] pry;
  logic signed [47:0] prz;
  logic signed [uvs_pkg::NORM_W-1:0] nx;
  logic signed [uvs_pkg::NORM_W-1:0] ny;
  logic signed [uvs_pkg::NORM_W-1:0] nz;
  logic signed [47:0] rad_s;

  assign rad_s = $signed(48'(sphere_radius));

  always_ff @(posedge clk) begin
    if (en[ST_SCALE]) begin
      prx <= 48'(dx) * rad_s;
      pry <= 48'(cp_r) * rad_s;
      prz <= 48'(dz) * rad_s;
      nx  <= uvs_pkg::NORM_W'(-uvs_pkg::round_away(64'(dx), 16));
      ny  <= uvs_pkg::NORM_W'(-uvs_pkg::round_away(64'(cp_r), 16));
      nz  <= uvs_pkg::NORM_W'(-uvs_pkg::round_away(64'(dz), 16));
    end
  end

  // Output register: positions rounded to Q8.8 and negated.
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      pos_x  <= uvs_pkg::POS_W'(-uvs_pkg::round_away(64'(prx), 30));
      pos_y  <= uvs_pkg::POS_W'(-uvs_pkg::round_away(64'(pry), 30));
      pos_z  <= uvs_pkg::POS_W'(-uvs_pkg::round_away(64'(prz), 30));
      norm_x <= nx;
      norm_y <= ny;
      norm_z <= nz;
    end
  end

  assign tex_u       = side[ST_OUT].tex_u;
  assign tex_v       = side[ST_OUT].tex_v;
  assign index_error = side[ST_OUT].err;

endmodule
